>>> src/rbsi_pkg.sv
// Shared constants and types for the ray / box slab intersection block.
package rbsi_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  // sideband that rides along with one slab quotient through the divider
  typedef struct packed {
    logic nneg;   // numerator negative
    logic neg;    // true quotient negative
    logic dzero;  // direction component is zero
    logic mzero;  // numerator is zero
  } side_t;

endpackage

>>> src/rbsi_if.sv
// Valid/ready channel interfaces for ray-box items and their results.
interface rbsi_in_if #(
  parameter int COORD_WIDTH = rbsi_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] box_lo_x;
  logic signed [COORD_WIDTH-1:0] box_lo_y;
  logic signed [COORD_WIDTH-1:0] box_lo_z;
  logic signed [COORD_WIDTH-1:0] box_hi_x;
  logic signed [COORD_WIDTH-1:0] box_hi_y;
  logic signed [COORD_WIDTH-1:0] box_hi_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
    output ready
  );
endinterface

interface rbsi_out_if #(
  parameter int COORD_WIDTH = rbsi_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          miss;
  logic signed [COORD_WIDTH-1:0] hit_distance;

  modport source (output valid, miss, hit_distance, input ready);
  modport sink (input valid, miss, hit_distance, output ready);
endinterface

>>> src/rbsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rbsi_div #(
  parameter int COORD_WIDTH = rbsi_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = rbsi_pkg::DEF_FRAC_BITS,
  localparam int DW         = COORD_WIDTH + 1 + FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DW-1:0]          dvd_i,
  input  logic [COORD_WIDTH-1:0] dvs_i,
  input  rbsi_pkg::side_t        side_i,
  output logic [DW-1:0]          q_o,
  output rbsi_pkg::side_t        side_o
);

  logic [COORD_WIDTH-1:0] rem_r  [1:DW];
  logic [DW-1:0]          dvd_r  [1:DW];
  logic [DW-1:0]          q_r    [1:DW];
  logic [COORD_WIDTH-1:0] dvs_r  [1:DW];
  rbsi_pkg::side_t        side_r [1:DW];

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [COORD_WIDTH-1:0] rem_src;
    logic [DW-1:0]          dvd_src;
    logic [DW-1:0]          q_src;
    logic [COORD_WIDTH-1:0] dvs_src;
    rbsi_pkg::side_t        side_src;
    logic [COORD_WIDTH:0]   rem2;
    logic                   ge;
    logic [COORD_WIDTH:0]   diff;

    if (s == 0) begin : g_first
      assign rem_src  = '0;
      assign dvd_src  = dvd_i;
      assign q_src    = '0;
      assign dvs_src  = dvs_i;
      assign side_src = side_i;
    end else begin : g_next
      assign rem_src  = rem_r[s];
      assign dvd_src  = dvd_r[s];
      assign q_src    = q_r[s];
      assign dvs_src  = dvs_r[s];
      assign side_src = side_r[s];
    end

    assign rem2 = {rem_src, dvd_src[DW-1]};
    assign ge   = (rem2 >= {1'b0, dvs_src});
    assign diff = rem2 - {1'b0, dvs_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? diff[COORD_WIDTH-1:0] : rem2[COORD_WIDTH-1:0];
        dvd_r[s+1]  <= {dvd_src[DW-2:0], 1'b0};
        q_r[s+1]    <= {q_src[DW-2:0], ge};
        dvs_r[s+1]  <= dvs_src;
        side_r[s+1] <= side_src;
      end
    end
  end

  assign q_o    = q_r[DW];
  assign side_o = side_r[DW];

endmodule

>>> src/ray_box_slab_intersect.sv
// Top level of the ray / axis-aligned box slab intersection pipeline.
//
// Usage: in_ch carries one ray (origin, direction) and one box (min and max
// corners) per item, all signed fixed point with FRAC_BITS fraction bits.
// out_ch returns one result per item, in order: miss, and hit_distance
// (entry distance if positive, else exit distance; 0 on a miss).
// Both channels are valid/ready; an item moves when valid and ready are high.
//
// Throughput: one item per cycle unless out_ch stalls. Stages from accept
// to out valid (default format Q16.16): input register, COORD_WIDTH +
// FRAC_BITS + 1 bit-per-stage divider stages (six lanes side by side, one
// per slab plane), quotient register, y stage and z stage.
//
// Stalls: when out_ch holds a result that is not taken, the whole pipeline
// freezes and in_ch.ready drops; nothing is lost or repeated. Bubbles travel
// with their cleared valid bits.
// Reset: synchronous, active low; clears every valid bit, so no result
// appears until items are fed. Payload registers are not reset.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbsi_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = rbsi_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  rbsi_in_if.sink           in_ch,
  rbsi_out_if.source        out_ch
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1 + FRAC_BITS;
  localparam logic [DW-1:0] Q_TOP = DW'(1) << (CW - 1);
  localparam logic signed [CW-1:0] SAT_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_NEG = {1'b1, {(CW-1){1'b0}}};

  // global advance: frozen only while a result waits at the output
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // ---- valid bits ----
  logic          v1_r;
  logic [DW-1:0] vdiv_r;
  logic          v2_r, v3_r, out_valid_r;

  // ---- stage 1: input register ----
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic signed [CW-1:0] lo_r  [3];
  logic signed [CW-1:0] hi_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      org_r[0] <= in_ch.origin_x;  org_r[1] <= in_ch.origin_y;
      org_r[2] <= in_ch.origin_z;
      dir_r[0] <= in_ch.dir_x;     dir_r[1] <= in_ch.dir_y;
      dir_r[2] <= in_ch.dir_z;
      lo_r[0]  <= in_ch.box_lo_x;  lo_r[1]  <= in_ch.box_lo_y;
      lo_r[2]  <= in_ch.box_lo_z;
      hi_r[0]  <= in_ch.box_hi_x;  hi_r[1]  <= in_ch.box_hi_y;
      hi_r[2]  <= in_ch.box_hi_z;
    end
  end

  // ---- six slab lanes: lane 2a is entry, 2a+1 exit, of axis a ----
  logic signed [CW-1:0] t_r [6];

  for (genvar l = 0; l < 6; l++) begin : g_lane
    localparam int AX = l / 2;
    logic                 back;
    logic signed [CW-1:0] plane;
    logic signed [CW:0]   num;
    logic [CW:0]          mag;
    logic [CW-1:0]        dmag;
    logic [DW-1:0]        dvd;
    rbsi_pkg::side_t      side_in, side_out;
    logic [DW-1:0]        q;
    logic signed [CW-1:0] t_nxt;

    // a negative direction swaps near and far planes
    assign back  = dir_r[AX][CW-1];
    assign plane = ((l % 2 == 0) != back) ? lo_r[AX] : hi_r[AX];
    assign num   = {plane[CW-1], plane} - {org_r[AX][CW-1], org_r[AX]};
    assign mag   = num[CW] ? (CW+1)'(-num) : num;
    assign dmag  = back ? CW'(-dir_r[AX]) : dir_r[AX];
    assign dvd   = {mag, {FRAC_BITS{1'b0}}};

    assign side_in.nneg  = num[CW];
    assign side_in.neg   = num[CW] ^ back;
    assign side_in.dzero = (dir_r[AX] == '0);
    assign side_in.mzero = (mag == '0);

    rbsi_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_div (
      .clk    (clk),
      .en     (en),
      .dvd_i  (dvd),
      .dvs_i  (dmag),
      .side_i (side_in),
      .q_o    (q),
      .side_o (side_out)
    );

    // sign and saturate the truncated quotient
    always_comb begin
      if (side_out.mzero) begin
        t_nxt = '0;
      end else if (side_out.dzero) begin
        t_nxt = side_out.nneg ? SAT_NEG : SAT_POS;
      end else if (side_out.neg) begin
        t_nxt = (q > Q_TOP) ? SAT_NEG : CW'(-q[CW-1:0]);
      end else begin
        t_nxt = (q > (Q_TOP - DW'(1))) ? SAT_POS : q[CW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) t_r[l] <= t_nxt;
    end
  end

  // ---- stage 3: narrow by y ----
  logic signed [CW-1:0] tmin3_r, tmax3_r, zin_r, zout_r;
  logic                 miss3_r;
  logic                 miss_y;

  assign miss_y = (t_r[1] < t_r[2]) || (t_r[3] < t_r[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      miss3_r <= miss_y;
      tmin3_r <= (t_r[0] < t_r[2]) ? t_r[2] : t_r[0];
      tmax3_r <= (t_r[3] < t_r[1]) ? t_r[3] : t_r[1];
      zin_r   <= t_r[4];
      zout_r  <= t_r[5];
    end
  end

  // ---- stage 4: narrow by z, pick the answer ----
  logic                 miss_nxt;
  logic signed [CW-1:0] tmin4, tmax4;
  logic signed [CW-1:0] dist_nxt;
  logic                 miss_r;
  logic signed [CW-1:0] dist_r;

  assign miss_nxt = miss3_r || (tmax3_r < zin_r) || (zout_r < tmin3_r);
  assign tmin4    = (tmin3_r < zin_r) ? zin_r : tmin3_r;
  assign tmax4    = (zout_r < tmax3_r) ? zout_r : tmax3_r;
  assign dist_nxt = miss_nxt ? '0 : ((tmin4 > 0) ? tmin4 : tmax4);

  always_ff @(posedge clk) begin
    if (en) begin
      miss_r <= miss_nxt;
      dist_r <= dist_nxt;
    end
  end

  // ---- valid chain ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      vdiv_r      <= '0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      vdiv_r      <= {vdiv_r[DW-2:0], v1_r};
      v2_r        <= vdiv_r[DW-1];
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.miss         = miss_r;
  assign out_ch.hit_distance = dist_r;

  // ---- checks ----
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && miss_r |-> dist_r == '0)
    else $error("miss result with nonzero distance");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !v1_r && !v3_r)
    else $error("valid bit survived reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vdiv_r) && $stable(v2_r) && $stable(v3_r))
    else $error("pipeline moved while output stalled");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the ray / axis-aligned box slab intersection block.
`timescale 1ns / 100ps

module testbench;

  localparam int CW   = rbsi_pkg::DEF_COORD_WIDTH;
  localparam int FB   = rbsi_pkg::DEF_FRAC_BITS;
  localparam int LAT  = CW + FB + 4;     // sizes the final wait for stray results
  localparam int WDOG = 4000;            // cycles without any handshake before giving up
  localparam int NRAND = 800;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t ONE  = coord_t'(1) <<< FB;
  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  // one ray-box pair as carried by the input channel
  typedef struct packed {
    coord_t ox, oy, oz;
    coord_t dx, dy, dz;
    coord_t lx, ly, lz;
    coord_t hx, hy, hz;
  } ray_box_t;

  // one result item
  typedef struct packed {
    logic   miss;
    coord_t hit_dist;
  } hit_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predicts each accepted pair and checks results in order.
  // -------------------------------------------------------------------------
  class hit_scoreboard;
    hit_t expected_hits[$];
    int   mismatches;
    int   n_hits, n_misses, n_checked;

    // (plane - org) / dir in fixed point, truncated toward zero, saturated
    static function coord_t slab_quot(coord_t plane, coord_t org, coord_t dir);
      longint          num;
      longint unsigned mag, dmag;
      logic [127:0]    q;
      bit              neg;
      num = longint'(plane) - longint'(org);
      if (num == 0) return '0;
      if (dir == 0) return (num < 0) ? CMIN : CMAX;
      mag  = (num < 0) ? longint'(-num) : longint'(num);
      dmag = (dir < 0) ? longint'(-longint'(dir)) : longint'(dir);
      q    = ({64'b0, mag} << FB) / {64'b0, dmag};
      neg  = (num < 0) != (dir < 0);
      if (neg) begin
        if (q > (128'd1 << (CW - 1))) return CMIN;
        return coord_t'(-q[CW-1:0]);
      end
      if (q > ((128'd1 << (CW - 1)) - 1)) return CMAX;
      return coord_t'(q[CW-1:0]);
    endfunction

    function void note_ray(ray_box_t r);
      coord_t org[3], dir[3], lo[3], hi[3];
      coord_t t_in, t_out, enter, leave;
      hit_t   h;
      org = '{r.ox, r.oy, r.oz};
      dir = '{r.dx, r.dy, r.dz};
      lo  = '{r.lx, r.ly, r.lz};
      hi  = '{r.hx, r.hy, r.hz};
      h.miss = 1'b0;
      t_in = '0;
      t_out = '0;
      for (int ax = 0; ax < 3; ax++) begin
        // a negative direction swaps near and far planes; zero counts as positive
        enter = slab_quot(dir[ax] < 0 ? hi[ax] : lo[ax], org[ax], dir[ax]);
        leave = slab_quot(dir[ax] < 0 ? lo[ax] : hi[ax], org[ax], dir[ax]);
        if (ax == 0) begin
          t_in = enter;
          t_out = leave;
        end else begin
          if (t_out < enter || leave < t_in) begin
            h.miss = 1'b1;
            break;
          end
          if (enter > t_in) t_in = enter;
          if (leave < t_out) t_out = leave;
        end
      end
      h.hit_dist = h.miss ? '0 : ((t_in > 0) ? t_in : t_out);
      if (h.miss) n_misses++;
      else n_hits++;
      expected_hits.push_back(h);
    endfunction

    function void check_result(logic miss, coord_t hit_dist);
      hit_t want;
      n_checked++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing pending: miss=%0b dist=%0d", miss, hit_dist);
        return;
      end
      want = expected_hits.pop_front();
      if (miss !== want.miss || hit_dist !== want.hit_dist) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected miss=%0b dist=%0d, got miss=%0b dist=%0d",
                   n_checked, want.miss, want.hit_dist, miss, hit_dist);
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels, block
  // -------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  rbsi_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  rbsi_out_if #(.COORD_WIDTH(CW)) out_ch ();

  ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  hit_scoreboard sb = new();

  bit     steady;        // when set, neither side idles
  int     quiet_cycles;
  int     n_sent;

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random back-pressure, checked at the rising edge.
  // -------------------------------------------------------------------------
  int stall_left;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left <= idle_len();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.miss, out_ch.hit_distance);
  end

  // watchdog: no handshake on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG) begin
      $display("ERROR: timeout, %0d results still pending", sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------

  // caller sits just after a falling edge; returns just after one
  task automatic send_ray(ray_box_t r);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.origin_x <= r.ox;
    in_ch.origin_y <= r.oy;
    in_ch.origin_z <= r.oz;
    in_ch.dir_x    <= r.dx;
    in_ch.dir_y    <= r.dy;
    in_ch.dir_z    <= r.dz;
    in_ch.box_lo_x <= r.lx;
    in_ch.box_lo_y <= r.ly;
    in_ch.box_lo_z <= r.lz;
    in_ch.box_hi_x <= r.hx;
    in_ch.box_hi_y <= r.hy;
    in_ch.box_hi_z <= r.hz;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_ray(r);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic ray_box_t mk(coord_t ox, coord_t oy, coord_t oz,
                                  coord_t dx, coord_t dy, coord_t dz,
                                  coord_t lx, coord_t ly, coord_t lz,
                                  coord_t hx, coord_t hy, coord_t hz);
    ray_box_t r;
    r = '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
    return r;
  endfunction

  // small fixed-point value around the origin, +-range units with random fraction
  function automatic coord_t near_val(int range);
    return coord_t'($urandom_range(0, (2 * range) << FB)) - (coord_t'(range) <<< FB);
  endfunction

  // any coordinate: mostly small, some raw 32-bit, some corners of the range
  function automatic coord_t any_val();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return near_val(16);
    if (r < 8) return coord_t'($urandom);
    case ($urandom_range(0, 4))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // direction component: zero now and then, tiny now and then
  function automatic coord_t dir_val();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return coord_t'($urandom_range(1, 4)) * (($urandom & 1) ? 1 : -1);
    return any_val();
  endfunction

  // well-formed pair: a real box and a ray aimed near its center
  function automatic ray_box_t aimed_ray();
    ray_box_t r;
    coord_t   lo[3], hi[3], org[3], dir[3];
    for (int ax = 0; ax < 3; ax++) begin
      lo[ax]  = near_val(20);
      hi[ax]  = lo[ax] + coord_t'($urandom_range(0, 8 << FB));
      org[ax] = near_val(40);
      // direction toward center, jittered so some graze and some miss
      dir[ax] = ((lo[ax] >>> 1) + (hi[ax] >>> 1) - org[ax]) + near_val(2);
      if ($urandom_range(0, 9) == 0) dir[ax] = -dir[ax];
      if ($urandom_range(0, 29) == 0) dir[ax] = '0;
    end
    // occasionally an inverted box on one axis
    if ($urandom_range(0, 19) == 0) begin
      r.lx = hi[0];
      hi[0] = lo[0];
      lo[0] = r.lx;
    end
    r = mk(org[0], org[1], org[2], dir[0], dir[1], dir[2],
           lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    return r;
  endfunction

  function automatic ray_box_t wild_ray();
    return mk(any_val(), any_val(), any_val(), dir_val(), dir_val(), dir_val(),
              any_val(), any_val(), any_val(), any_val(), any_val(), any_val());
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  localparam coord_t HALF = ONE >>> 1;

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    out_ch.ready = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
    {in_ch.box_lo_x, in_ch.box_lo_y, in_ch.box_lo_z} = '0;
    {in_ch.box_hi_x, in_ch.box_hi_y, in_ch.box_hi_z} = '0;
    stall_left   = 0;
    steady       = 1'b1;
    quiet_cycles = 0;
    n_sent       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unit box [0,1]^3 unless noted
    // straight hit along +x, entry distance 5
    send_ray(mk(-5 * ONE, HALF, HALF, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // along -x from the far side
    send_ray(mk(6 * ONE, HALF, HALF, -ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // origin inside the box: entry negative, exit reported
    send_ray(mk(HALF, HALF, HALF, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
    // plain miss, offset in y
    send_ray(mk(-5 * ONE, 3 * ONE, HALF, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // exit on x equals entry on y: touching intervals are a hit
    send_ray(mk(-ONE, 0, HALF, ONE, ONE, 0, 0, 2 * ONE, 0, ONE, 3 * ONE, ONE));
    // zero direction on the slab edge (zero numerator)
    send_ray(mk(-ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // zero direction outside the slab: saturated planes, miss
    send_ray(mk(-ONE, 2 * ONE, HALF, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // tiny direction, far plane: positive quotient overflows
    send_ray(mk(0, 0, 0, 1, 1, 1, 1000 * ONE, 1000 * ONE, 1000 * ONE,
                2000 * ONE, 2000 * ONE, 2000 * ONE));
    // tiny negative direction: negative overflow
    send_ray(mk(0, 0, 0, -1, -1, -1, 1000 * ONE, 1000 * ONE, 1000 * ONE,
                2000 * ONE, 2000 * ONE, 2000 * ONE));
    // box entirely behind the ray: negative exit distance
    send_ray(mk(5 * ONE, HALF, HALF, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    // inverted box, min above max on every axis
    send_ray(mk(-5 * ONE, HALF, HALF, ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0));
    // all directions negative, diagonal hit
    send_ray(mk(4 * ONE, 4 * ONE, 4 * ONE, -ONE, -ONE, -ONE, 0, 0, 0, ONE, ONE, ONE));
    // field extremes
    send_ray(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_ray(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_ray(mk(CMAX, CMIN, 0, -1, 1, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_ray(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_ray(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // exact quotient on the positive edge of the range
    send_ray(mk(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, CMAX, CMAX, CMAX));
    // exact quotient on the negative edge
    send_ray(mk(0, 0, 0, ONE, ONE, ONE, CMIN, CMIN, CMIN, 0, 0, 0));

    // random: mostly aimed rays, the rest anything; idling toggled in bursts
    steady = 1'b0;
    for (int i = 0; i < NRAND; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) send_ray(aimed_ray());
      else send_ray(wild_ray());
    end
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    // wait on so that a stray extra result would still show up
    repeat (2 * LAT) @(posedge clk);

    $display("Sent %0d ray-box pairs (%0d predicted hits, %0d misses), %0d results checked.",
             n_sent, sb.n_hits, sb.n_misses, sb.n_checked);
    $display("Covered zero and tiny directions, saturation, inverted boxes, random stalls.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
